FILE: rtl/core/echo_round_trip_tracker_top_macros.svh
// Assertion macros for the echo round-trip tracker
`ifndef ECHO_ROUND_TRIP_TRACKER_TOP_MACROS_SVH
`define ECHO_ROUND_TRIP_TRACKER_TOP_MACROS_SVH

// same-cycle implication, gated by the active-low reset
`define ERTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ertt assertion failed");

// next-cycle implication, gated by the active-low reset
`define ERTT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ertt assertion failed");

`endif

FILE: rtl/core/ertt_pkg.sv
// Shared types and constants of the echo round-trip tracker
package ertt_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);

    localparam logic [1:0] OP_SEND   = 2'd0;
    localparam logic [1:0] OP_REPLY  = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;

    localparam logic [31:0] TIMEOUT_RST = 32'd1000;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] seq;
        logic [31:0] time_ms;
        logic        ended_by_timeout;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [15:0] success_count;
        logic [15:0] failure_count;
        logic [31:0] avg_rtt;
        logic [31:0] min_rtt;
        logic [31:0] max_rtt;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_start;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_finish;
        logic div_done;
    } t_dp_sts;

endpackage

FILE: rtl/core/ertt_ctrl.sv
// Controller state machine of the echo round-trip tracker
module ertt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  ertt_pkg::t_dp_sts i_sts,
    output ertt_pkg::t_dp_cmd o_cmd
);
    import ertt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = w_accept;
        o_cmd.eval      = (r_state == S_EVAL);
        o_cmd.div_start = (r_state == S_EVAL) && i_sts.is_finish;
        o_cmd.commit    = (r_state == S_COMMIT) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_state <= i_sts.is_finish ? S_DIV : S_COMMIT;
                end
                S_DIV: begin
                    if (i_sts.div_done) r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/ertt_div.sv
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor
module ertt_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_quot;
    logic [15:0] r_rem;
    logic [15:0] r_divisor;
    logic [16:0] w_shift;
    logic        w_ge;
    logic [16:0] w_diff;

    assign w_shift = {r_rem, r_quot[31]};
    assign w_ge    = (w_shift >= {1'b0, r_divisor});
    assign w_diff  = w_shift - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[15:0] : w_shift[15:0];
            r_quot <= {r_quot[30:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: rtl/core/ertt_dp.sv
// Datapath: slot table, statistics, timeout register and result register
module ertt_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ertt_pkg::t_dp_cmd  i_cmd,
    output ertt_pkg::t_dp_sts  o_sts,
    input  ertt_pkg::t_in_item i_in_item,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_data,
    output ertt_pkg::t_out_item o_out_item
);
    import ertt_pkg::*;

    logic [15:0]      mem_seq   [TABLE_SLOTS];
    logic [31:0]      mem_start [TABLE_SLOTS];

    t_in_item         r_item;
    logic [15:0]      r_rd_seq;
    logic [31:0]      r_rd_start;
    logic [31:0]      r_timeout;
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [TABLE_SLOTS-1:0] r_answered;
    logic [15:0]      r_sent;
    logic [15:0]      r_ans;
    logic [31:0]      r_min;
    logic [31:0]      r_max;
    logic [31:0]      r_sum;
    logic [31:0]      r_rtt;
    logic             r_hit;
    t_out_item        r_out;
    t_out_item        n_out;

    logic [IDX_W-1:0] w_idx;
    logic [31:0]      w_rtt;
    logic             w_hit;
    logic [32:0]      w_sum_add;
    logic [31:0]      w_quot;
    logic             w_div_done;

    assign w_idx     = r_item.seq[IDX_W-1:0];
    assign w_rtt     = r_item.time_ms - r_rd_start;
    assign w_hit     = r_valid[w_idx] && !r_answered[w_idx] && (r_rd_seq == r_item.seq)
                       && (w_rtt <= r_timeout);
    assign w_sum_add = {1'b0, r_sum} + {1'b0, r_rtt};

    ertt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_ans),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign o_sts.is_finish = (r_item.opcode == OP_FINISH);
    assign o_sts.div_done  = w_div_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_item.opcode == OP_SEND)) begin
            mem_seq[w_idx]   <= r_item.seq;
            mem_start[w_idx] <= r_item.time_ms;
        end
        if (i_cmd.load) begin
            r_rd_seq   <= mem_seq[i_in_item.seq[IDX_W-1:0]];
            r_rd_start <= mem_start[i_in_item.seq[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_in_item;
        if (i_cmd.eval) begin
            r_rtt <= w_rtt;
            r_hit <= w_hit;
        end
        if (i_cmd.commit) r_out <= n_out;
    end

    always_comb begin
        n_out = '0;
        case (r_item.opcode)
            OP_SEND: begin
                n_out.status = 1'b0;
            end
            OP_REPLY: begin
                n_out.status = !r_hit;
            end
            OP_FINISH: begin
                n_out.success_count = r_ans;
                n_out.failure_count = (r_sent > r_ans) ? (r_sent - r_ans) : 16'd0;
                n_out.avg_rtt       = (r_ans != 16'd0) ? w_quot : 32'd0;
                n_out.min_rtt       = r_item.ended_by_timeout ? 32'd0 : r_min;
                n_out.max_rtt       = r_item.ended_by_timeout ? 32'd0 : r_max;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RST;
            r_valid    <= '0;
            r_answered <= '0;
            r_sent     <= '0;
            r_ans      <= '0;
            r_min      <= '0;
            r_max      <= '0;
            r_sum      <= '0;
        end else begin
            if (i_cfg_we) r_timeout <= i_cfg_data;
            if (i_cmd.commit) begin
                case (r_item.opcode)
                    OP_SEND: begin
                        r_valid[w_idx]    <= 1'b1;
                        r_answered[w_idx] <= 1'b0;
                        if (r_sent != 16'hFFFF) r_sent <= r_sent + 16'd1;
                    end
                    OP_REPLY: begin
                        if (r_hit) begin
                            r_answered[w_idx] <= 1'b1;
                            if (r_ans == 16'd0) begin
                                r_min <= r_rtt;
                                r_max <= r_rtt;
                                r_sum <= r_rtt;
                            end else begin
                                if (r_rtt < r_min) r_min <= r_rtt;
                                if (r_rtt > r_max) r_max <= r_rtt;
                                r_sum <= w_sum_add[32] ? 32'hFFFF_FFFF : w_sum_add[31:0];
                            end
                            if (r_ans != 16'hFFFF) r_ans <= r_ans + 16'd1;
                        end
                    end
                    OP_FINISH: begin
                        r_valid    <= '0;
                        r_answered <= '0;
                        r_sent     <= '0;
                        r_ans      <= '0;
                        r_min      <= '0;
                        r_max      <= '0;
                        r_sum      <= '0;
                    end
                    default: begin
                        r_sent <= r_sent;
                    end
                endcase
            end
        end
    end

    assign o_out_item = r_out;

endmodule

FILE: rtl/core/echo_round_trip_tracker_top.sv
// Echo round-trip tracker: send/reply/finish events in, one result per event out
//
// Input channel i_in_valid/o_in_stall carries one event (send, reply, finish).
// Output channel o_out_valid/i_out_stall returns exactly one result per event.
// Config channel i_cfg_valid/o_cfg_ready writes timeout_ms; ready is always high.
// Send and reply events: the slot table is read at the transfer, then the
// controller passes through evaluate and commit before the result is valid.
// A finish event adds a pass through the bit-serial sum/count divider.
// One event is in flight at a time; o_in_stall stays high until its result
// is loaded into the output register.
// The output register holds a result while i_out_stall is high; the next
// event may be accepted meanwhile, but its commit waits for the register.
// Reset (synchronous, active low) clears slot valid/answered bits, counts and
// statistics at once and sets timeout_ms to 1000; no clearing pass needed.
module echo_round_trip_tracker_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ertt_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ertt_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_data
);
    import ertt_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ertt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ertt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_out_item (o_out_item)
    );

endmodule

FILE: rtl/core/ertt_checker.sv
// Port-level assertions of the echo round-trip tracker and their bind
`include "echo_round_trip_tracker_top_macros.svh"

module ertt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ertt_pkg::t_out_item o_out_item
);
    import ertt_pkg::*;

    logic w_out_wait;
    logic w_in_xfer;
    logic w_reject;
    logic w_zero_stats;

    assign w_out_wait   = o_out_valid && i_out_stall;
    assign w_in_xfer    = i_in_valid && !o_in_stall;
    assign w_reject     = o_out_valid && o_out_item.status;
    assign w_zero_stats = (o_out_item.success_count == 16'd0) && (o_out_item.avg_rtt == 32'd0)
                          && (o_out_item.max_rtt == 32'd0);

    `ERTT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_out_wait, o_out_valid && $stable(o_out_item))
    `ERTT_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, w_in_xfer, o_in_stall)
    `ERTT_ASSERT_IMP(a_reject_zero, i_clk, i_rst_n, w_reject, w_zero_stats)
    `ERTT_ASSERT_IMP(a_min_le_max, i_clk, i_rst_n, o_out_valid, o_out_item.min_rtt <= o_out_item.max_rtt)

endmodule

bind echo_round_trip_tracker_top ertt_checker u_ertt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
